@@ rtl/core/clx_pkg.sv @@
// Shared types, constants and character classes for the C subset lexer.
// No dependencies; every other file of the block imports this package.
package clx_pkg;

	localparam int LexemeMax = 64;
	localparam logic [5:0] CutLen = 6'(LexemeMax - 1);
	localparam int QDepth = 4;

	// scan modes
	localparam logic [3:0] MODE_IDLE    = 4'd0;
	localparam logic [3:0] MODE_SLASH   = 4'd1;
	localparam logic [3:0] MODE_REL     = 4'd2;
	localparam logic [3:0] MODE_IDENT   = 4'd3;
	localparam logic [3:0] MODE_INT     = 4'd4;
	localparam logic [3:0] MODE_DOT     = 4'd5;
	localparam logic [3:0] MODE_FRAC    = 4'd6;
	localparam logic [3:0] MODE_COMMENT = 4'd7;

	// token kinds
	localparam logic [3:0] KIND_IDENT  = 4'd0;
	localparam logic [3:0] KIND_NUMBER = 4'd1;
	localparam logic [3:0] KIND_OP     = 4'd2;
	localparam logic [3:0] KIND_REL    = 4'd3;
	localparam logic [3:0] KIND_ASSIGN = 4'd4;
	localparam logic [3:0] KIND_LPAR   = 4'd5;
	localparam logic [3:0] KIND_RPAR   = 4'd6;
	localparam logic [3:0] KIND_LCURLY = 4'd7;
	localparam logic [3:0] KIND_RCURLY = 4'd8;
	localparam logic [3:0] KIND_SEMI   = 4'd9;
	localparam logic [3:0] KIND_IF     = 4'd10;
	localparam logic [3:0] KIND_ELSE   = 4'd11;
	localparam logic [3:0] KIND_LOOP   = 4'd12;
	localparam logic [3:0] KIND_EOF    = 4'd13;
	localparam logic [3:0] KIND_BAD    = 4'd14;

	localparam logic [39:0] KW_IF    = {24'd0, "if"};
	localparam logic [39:0] KW_ELSE  = {8'd0, "else"};
	localparam logic [39:0] KW_WHILE = "while";

	localparam logic [16:0] CAP_RESET = 17'd1024;

	typedef struct packed {
		logic [3:0]  mode;
		logic [7:0]  pend;
		logic [31:0] tstart;
		logic [5:0]  len;
		logic [39:0] kwpre;
		logic [63:0] digits;
		logic [5:0]  frac;
		logic [31:0] offset;
		logic [23:0] line;
		logic [16:0] emitted;
		logic [31:0] errors;
	} scan_state_t;

	typedef struct packed {
		logic [31:0] errors;
		logic [5:0]  frac;
		logic [63:0] mant;
		logic [23:0] line;
		logic [5:0]  len;
		logic [31:0] start;
		logic [7:0]  lead;
		logic [3:0]  kind;
	} tok_t;

	typedef struct packed {
		logic       last;
		tok_t       tok;
	} beat_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

endpackage

@@ rtl/core/c_subset_lexer.sv @@
// Usage of c_subset_lexer, a streaming lexer for a small C subset.
// Input stream s_axis_*: one source byte per beat in tdata[7:0]; byte 0 ends
//   the text, flushes the pending token, emits an end token and restarts the
//   per-text counters (offset, line, error and token counts).
// Output stream m_axis_*: one token per beat; tlast marks the final token
//   caused by one input byte. A byte may cause zero to three tokens.
// Configuration: cap_we/cap_wdata write the token capacity (reset 1024);
//   write only while the block is idle.
// Ordering: tokens caused by a byte are written into the output queue when the
//   byte is accepted and leave behind any tokens already queued. Throughput: one
//   byte per cycle while the receiver keeps up; the rate is set by the four-entry
//   output queue, which takes a byte only while it holds at most one token, so a
//   byte yielding several tokens holds the input until the queue drains to one.
// Reset (arst_n low, asynchronous) clears the scan state and the queue.
// When the receiver stalls, tokens wait in the queue and s_axis_tready drops
// once fewer than three entries are free.
module c_subset_lexer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] source_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] token_kind, [11:4] lead_symbol, [43:12] start_offset,
	// [49:44] lexeme_length, [73:50] line_number, [137:74] number_mantissa,
	// [143:138] fraction_digits, [175:144] errors_so_far
	output logic [175:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cap_we,
	input  logic [16:0]  cap_wdata
);
	import clx_pkg::*;

	scan_state_t st_q, st_nxt;
	logic [16:0] cap_q;
	beat_t       beats [3];
	beat_t       head;
	logic [2:0]  emit;
	logic        room, acc;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = room;

	clx_step u_step (
		.cur   (st_q),
		.c     (s_axis_tdata),
		.cap   (cap_q),
		.nxt   (st_nxt),
		.beats (beats),
		.emit  (emit)
	);

	clx_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc ? emit : 3'd0),
		.din       (beats),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dout      (head)
	);

	assign m_axis_tdata = head.tok;
	assign m_axis_tlast = head.last;

	// hold scan state; advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_IDLE, line: 24'd1, default: '0};
			cap_q <= CAP_RESET;
		end else begin
			if (acc) st_q <= st_nxt;
			if (cap_we) cap_q <= cap_wdata;
		end
	end

endmodule

@@ rtl/core/clx_step.sv @@
// Next-state and token logic for one source byte of the lexer.
// Depends on clx_pkg; purely combinational, feeds the state register and queue.
module clx_step (
	input  clx_pkg::scan_state_t cur,
	input  logic [7:0]           c,
	input  logic [16:0]          cap,
	output clx_pkg::scan_state_t nxt,
	output clx_pkg::beat_t       beats [3],
	output logic [2:0]           emit
);
	import clx_pkg::*;

	tok_t        ta, tb, tc;
	logic        wa, wb, wc;
	logic        inca, incb, incc;
	logic [63:0] dv;
	logic [5:0]  fc, ln;
	logic [3:0]  md;
	logic        do_start, do_end;
	logic [32:0] dot_sum;
	logic [67:0] dig_wide;
	logic [31:0] e1, e2, e3;
	logic [17:0] cnt0, cnt1, cnt2;
	logic        oka, okb, okc;

	function automatic tok_t mk(input logic [3:0] k, input logic [7:0] ld,
		input logic [31:0] st, input logic [5:0] l, input logic [63:0] m,
		input logic [5:0] f);
		tok_t t;
		t = '0;
		t.kind = k; t.lead = ld; t.start = st; t.len = l; t.mant = m; t.frac = f;
		return t;
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] v, input logic en);
		return (en && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
	endfunction

	// decimal shift-in of the incoming digit, saturating
	assign dig_wide = ({4'd0, cur.digits} << 3) + ({4'd0, cur.digits} << 1)
		+ {60'd0, c - 8'h30};
	assign dv = (dig_wide[67:64] != 4'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : dig_wide[63:0];
	assign dot_sum = {1'b0, cur.tstart} + {27'd0, cur.len};

	// scan the byte: flush token, second token, starting token
	always_comb begin
		nxt = cur;
		ta = '0; tb = '0; tc = '0;
		wa = 1'b0; wb = 1'b0; wc = 1'b0;
		inca = 1'b0; incb = 1'b0; incc = 1'b0;
		do_start = 1'b0; do_end = 1'b0;
		ln = cur.len; fc = cur.frac; md = cur.mode;
		if (c == 8'd0) begin
			do_end = 1'b1;
			unique case (cur.mode)
				MODE_SLASH: begin
					wa = 1'b1; ta = mk(KIND_OP, "/", cur.tstart, 6'd1, '0, '0);
				end
				MODE_REL: begin
					wa = 1'b1;
				end
				MODE_IDENT, MODE_INT, MODE_FRAC: wa = 1'b1;
				MODE_DOT: begin
					wa = 1'b1; wb = 1'b1;
				end
				default: ;
			endcase
		end else begin
			unique case (cur.mode)
				MODE_COMMENT: begin
					if (c == 8'h0A) do_start = 1'b1;
				end
				MODE_SLASH: begin
					if (c == "/") md = MODE_COMMENT;
					else begin
						wa = 1'b1; ta = mk(KIND_OP, "/", cur.tstart, 6'd1, '0, '0);
						do_start = 1'b1;
					end
				end
				MODE_REL: begin
					wa = 1'b1;
					if (c == "=") begin
						ta = mk(KIND_REL, cur.pend, cur.tstart, 6'd2, '0, '0);
						md = MODE_IDLE;
					end else do_start = 1'b1;
				end
				MODE_IDENT: begin
					if (is_letter(c) || is_digit(c)) begin
						if (cur.len < 6'd5) nxt.kwpre = {cur.kwpre[31:0], c};
						ln = cur.len + 6'd1;
						if (ln >= CutLen) begin
							wa = 1'b1; md = MODE_IDLE;
						end
					end else begin
						wa = 1'b1; do_start = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_digit(c)) begin
						ln = cur.len + 6'd1; nxt.digits = dv;
						if (ln >= CutLen) begin
							wa = 1'b1; md = MODE_IDLE;
						end
					end else if (c == ".") md = MODE_DOT;
					else begin
						wa = 1'b1; do_start = 1'b1;
					end
				end
				MODE_DOT: begin
					if (is_digit(c)) begin
						ln = cur.len + 6'd1;
						if (ln >= CutLen) begin
							wa = 1'b1; do_start = 1'b1;
						end else begin
							ln = ln + 6'd1; nxt.digits = dv; fc = 6'd1; md = MODE_FRAC;
							if (ln >= CutLen) begin
								wa = 1'b1; md = MODE_IDLE;
							end
						end
					end else begin
						wa = 1'b1; wb = 1'b1; do_start = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_digit(c)) begin
						ln = cur.len + 6'd1; nxt.digits = dv; fc = cur.frac + 6'd1;
						if (ln >= CutLen) begin
							wa = 1'b1; md = MODE_IDLE;
						end
					end else begin
						wa = 1'b1; do_start = 1'b1;
					end
				end
				default: do_start = 1'b1;
			endcase
		end

		// flush token of the pending lexeme
		if (wa && !(cur.mode == MODE_SLASH) && !(cur.mode == MODE_REL && c == "=")) begin
			if (cur.mode == MODE_IDENT) begin
				ta = mk(KIND_IDENT, cur.pend, cur.tstart, ln, '0, '0);
				if (ln == 6'd2 && nxt.kwpre == KW_IF) ta.kind = KIND_IF;
				else if (ln == 6'd4 && nxt.kwpre == KW_ELSE) ta.kind = KIND_ELSE;
				else if (ln == 6'd5 && nxt.kwpre == KW_WHILE) ta.kind = KIND_LOOP;
			end else if (cur.mode == MODE_REL) begin
				ta = mk(KIND_BAD, cur.pend, cur.tstart, 6'd1, '0, '0);
				if (cur.pend == "<" || cur.pend == ">") ta.kind = KIND_REL;
				else if (cur.pend == "=") ta.kind = KIND_ASSIGN;
				else inca = 1'b1;
			end else begin
				ta = mk(KIND_NUMBER, cur.pend, cur.tstart, ln, nxt.digits, fc);
			end
		end
		// stray point after a number
		if (wb) begin
			incb = 1'b1;
			tb = mk(KIND_BAD, ".", dot_sum[32] ? 32'hFFFF_FFFF : dot_sum[31:0], 6'd1, '0, '0);
		end

		nxt.mode = md; nxt.len = ln; nxt.frac = fc;
		// start of a new lexeme
		if (do_start) begin
			nxt.mode = MODE_IDLE;
			if (c == 8'h0A) begin
				if (cur.line != 24'hFF_FFFF) nxt.line = cur.line + 24'd1;
			end else if (!is_space(c)) begin
				nxt.pend = c; nxt.tstart = cur.offset; nxt.len = 6'd1;
				tc = mk(KIND_BAD, c, cur.offset, 6'd1, '0, '0);
				if (is_letter(c)) begin
					nxt.mode = MODE_IDENT; nxt.kwpre = {32'd0, c};
				end else if (is_digit(c)) begin
					nxt.mode = MODE_INT; nxt.digits = {56'd0, c - 8'h30}; nxt.frac = '0;
				end else if (c == "/") nxt.mode = MODE_SLASH;
				else if (c == "<" || c == ">" || c == "=" || c == "!") nxt.mode = MODE_REL;
				else begin
					wc = 1'b1;
					priority if (c == "+" || c == "-" || c == "*") tc.kind = KIND_OP;
					else if (c == "(") tc.kind = KIND_LPAR;
					else if (c == ")") tc.kind = KIND_RPAR;
					else if (c == "{") tc.kind = KIND_LCURLY;
					else if (c == "}") tc.kind = KIND_RCURLY;
					else if (c == ";") tc.kind = KIND_SEMI;
					else incc = 1'b1;
				end
			end
		end
		if (do_end) begin
			wc = 1'b1;
			tc = mk(KIND_EOF, 8'd0, cur.offset, 6'd0, '0, '0);
		end

		// error counts as each token leaves
		e1 = sat_inc32(cur.errors, inca);
		e2 = sat_inc32(e1, incb);
		e3 = sat_inc32(e2, incc);
		ta.errors = e1; tb.errors = e2; tc.errors = e3;
		ta.line = cur.line; tb.line = cur.line; tc.line = cur.line;

		// capacity gate, in emit order
		cnt0 = {1'b0, cur.emitted} + 18'd1;
		oka = wa && (cnt0 < {1'b0, cap});
		cnt1 = cnt0 + {17'd0, oka};
		okb = wb && (cnt1 < {1'b0, cap});
		cnt2 = cnt1 + {17'd0, okb};
		okc = wc && (cnt2 < {1'b0, cap});
		nxt.emitted = cnt2[16:0] - 17'd1 + {16'd0, okc};
		nxt.errors = e3;
		if (!do_end) begin
			nxt.offset = (cur.offset != 32'hFFFF_FFFF) ? cur.offset + 32'd1 : cur.offset;
		end else begin
			nxt = '0;
			nxt.line = 24'd1;
		end
	end

	assign emit = {okc, okb, oka};
	assign beats[0] = '{last: oka && !okb && !okc, tok: ta};
	assign beats[1] = '{last: okb && !okc, tok: tb};
	assign beats[2] = '{last: okc, tok: tc};

endmodule

@@ rtl/core/clx_outq.sv @@
// Four-entry token queue that takes up to three beats a cycle and drains one.
// Depends on clx_pkg; sits between the scan logic and the output stream.
module clx_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           push,
	input  clx_pkg::beat_t       din [3],
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output clx_pkg::beat_t       dout
);
	import clx_pkg::*;

	beat_t      mem_q [QDepth];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;
	logic       pop;
	logic [1:0] off1, off2;

	assign n_push = 2'(push[0]) + 2'(push[1]) + 2'(push[2]);
	assign off1 = 2'(push[0]);
	assign off2 = 2'(push[0]) + 2'(push[1]);
	assign pop = out_valid && out_ready;
	assign room = cnt_q <= 3'd1;
	assign out_valid = cnt_q != 3'd0;
	assign dout = mem_q[rp_q];

	// store the packed beats
	always_ff @(posedge clk) begin
		if (push[0]) mem_q[wp_q] <= din[0];
		if (push[1]) mem_q[wp_q + off1] <= din[1];
		if (push[2]) mem_q[wp_q + off2] <= din[2];
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + n_push;
			rp_q <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(n_push) - 3'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("token queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push != 3'd0) |-> room) else $error("push into full token queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push == 3'd0 && !pop) |=> $stable(cnt_q)) else $error("count moved while idle");
`endif

endmodule

@@ sim/clx_token_checker.sv @@
// Token checker for the C subset lexer: watches both stream channels and the
// capacity port, predicts the token stream and compares every output beat.
// Depends on clx_pkg for token kinds, scan modes and the token layout.
module clx_token_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [175:0] m_axis_tdata,
	input  logic         m_axis_tlast,
	input  logic         cap_we,
	input  logic [16:0]  cap_wdata,
	output int           fail_count,
	output int           tokens_pending,
	output int           tokens_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import clx_pkg::*;

	// predicted lexer state
	logic [16:0] capacity;
	logic [3:0]  mode;
	logic [7:0]  pend;
	logic [31:0] tstart;
	int          len;
	logic [39:0] kwpre;
	logic [63:0] digits;
	int          frac;
	logic [31:0] offset;
	logic [23:0] line;
	int          emitted;
	logic [31:0] errors;

	beat_t expected_tokens[$];
	beat_t byte_tokens[$];

	function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task clear_text();
		mode = MODE_IDLE;
		pend = '0;
		tstart = '0;
		len = 0;
		kwpre = '0;
		digits = '0;
		frac = 0;
		offset = '0;
		line = 24'd1;
		emitted = 0;
		errors = '0;
	endtask

	task count_error();
		if (errors != 32'hFFFF_FFFF) errors++;
	endtask

	// drop the token once capacity is reached or the byte already made three
	task put_token(input logic [3:0] kind, input logic [7:0] lead, input logic [31:0] start,
			input int n, input logic [63:0] mant, input int nfrac);
		beat_t b;
		if (emitted + 1 >= int'(capacity)) return;
		if (byte_tokens.size() >= 3) return;
		b.last = 1'b0;
		b.tok.kind = kind;
		b.tok.lead = lead;
		b.tok.start = start;
		b.tok.len = 6'(n);
		b.tok.line = line;
		b.tok.mant = mant;
		b.tok.frac = 6'(nfrac);
		b.tok.errors = errors;
		byte_tokens.push_back(b);
		emitted++;
	endtask

	task add_digit(input logic [7:0] c);
		logic [63:0] d;
		d = 64'(c - "0");
		if (digits > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) digits = 64'hFFFF_FFFF_FFFF_FFFF;
		else digits = digits * 10 + d;
	endtask

	task close_ident();
		logic [3:0] kind;
		kind = KIND_IDENT;
		if (len == 2 && kwpre == KW_IF) kind = KIND_IF;
		else if (len == 4 && kwpre == KW_ELSE) kind = KIND_ELSE;
		else if (len == 5 && kwpre == KW_WHILE) kind = KIND_LOOP;
		put_token(kind, pend, tstart, len, '0, 0);
		mode = MODE_IDLE;
	endtask

	task close_number();
		put_token(KIND_NUMBER, pend, tstart, len, digits, frac);
		mode = MODE_IDLE;
	endtask

	task close_single_rel();
		if (pend == "<" || pend == ">") put_token(KIND_REL, pend, tstart, 1, '0, 0);
		else if (pend == "=") put_token(KIND_ASSIGN, pend, tstart, 1, '0, 0);
		else begin
			count_error();
			put_token(KIND_BAD, pend, tstart, 1, '0, 0);
		end
		mode = MODE_IDLE;
	endtask

	// number ended by a point with no digit after it
	task close_dot_error();
		logic [31:0] dot_at;
		dot_at = add_sat32(tstart, 32'(len));
		close_number();
		count_error();
		put_token(KIND_BAD, ".", dot_at, 1, '0, 0);
	endtask

	task open_char(input logic [7:0] c);
		mode = MODE_IDLE;
		if (c == 8'd10) begin
			if (line != 24'hFF_FFFF) line++;
			return;
		end
		if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
		pend = c;
		tstart = offset;
		len = 1;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") begin
			mode = MODE_IDENT;
			kwpre = 40'(c);
		end else if (c >= "0" && c <= "9") begin
			mode = MODE_INT;
			digits = 64'(c - "0");
			frac = 0;
		end else if (c == "/") mode = MODE_SLASH;
		else if (c == "<" || c == ">" || c == "=" || c == "!") mode = MODE_REL;
		else if (c == "+" || c == "-" || c == "*") put_token(KIND_OP, c, offset, 1, '0, 0);
		else if (c == "(") put_token(KIND_LPAR, c, offset, 1, '0, 0);
		else if (c == ")") put_token(KIND_RPAR, c, offset, 1, '0, 0);
		else if (c == "{") put_token(KIND_LCURLY, c, offset, 1, '0, 0);
		else if (c == "}") put_token(KIND_RCURLY, c, offset, 1, '0, 0);
		else if (c == ";") put_token(KIND_SEMI, c, offset, 1, '0, 0);
		else begin
			count_error();
			put_token(KIND_BAD, c, offset, 1, '0, 0);
		end
	endtask

	// advance the predicted scanner by one source byte
	task lex_byte(input logic [7:0] c);
		logic alnum;
		logic dig;
		byte_tokens.delete();
		dig = c >= "0" && c <= "9";
		alnum = dig || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
		if (c == 8'd0) begin
			case (mode)
				MODE_SLASH: put_token(KIND_OP, "/", tstart, 1, '0, 0);
				MODE_REL: close_single_rel();
				MODE_IDENT: close_ident();
				MODE_INT, MODE_FRAC: close_number();
				MODE_DOT: close_dot_error();
				default: ;
			endcase
			put_token(KIND_EOF, 8'd0, offset, 0, '0, 0);
			clear_text();
		end else begin
			case (mode)
				MODE_COMMENT: if (c == 8'd10) open_char(c);
				MODE_SLASH: begin
					if (c == "/") mode = MODE_COMMENT;
					else begin
						put_token(KIND_OP, "/", tstart, 1, '0, 0);
						open_char(c);
					end
				end
				MODE_REL: begin
					if (c == "=") begin
						put_token(KIND_REL, pend, tstart, 2, '0, 0);
						mode = MODE_IDLE;
					end else begin
						close_single_rel();
						open_char(c);
					end
				end
				MODE_IDENT: begin
					if (alnum) begin
						if (len < 5) kwpre = {kwpre[31:0], c};
						len++;
						if (len >= int'(CutLen)) close_ident();
					end else begin
						close_ident();
						open_char(c);
					end
				end
				MODE_INT: begin
					if (dig) begin
						len++;
						add_digit(c);
						if (len >= int'(CutLen)) close_number();
					end else if (c == ".") mode = MODE_DOT;
					else begin
						close_number();
						open_char(c);
					end
				end
				MODE_DOT: begin
					if (dig) begin
						len++;
						if (len >= int'(CutLen)) begin
							close_number();
							open_char(c);
						end else begin
							len++;
							add_digit(c);
							frac = 1;
							mode = MODE_FRAC;
							if (len >= int'(CutLen)) close_number();
						end
					end else begin
						close_dot_error();
						open_char(c);
					end
				end
				MODE_FRAC: begin
					if (dig) begin
						len++;
						add_digit(c);
						frac++;
						if (len >= int'(CutLen)) close_number();
					end else begin
						close_number();
						open_char(c);
					end
				end
				default: open_char(c);
			endcase
			offset = add_sat32(offset, 32'd1);
		end
		if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
		foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
	endtask

	function automatic int check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	// compare output beats, then fold in accepted bytes and capacity writes
	always @(posedge clk or negedge arst_n) begin
		tok_t  got;
		beat_t want;
		int    bad;
		if (!arst_n) begin
			capacity = CAP_RESET;
			clear_text();
			expected_tokens.delete();
			fail_count = 0;
			tokens_checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = tok_t'(m_axis_tdata);
				if (expected_tokens.size() == 0) begin
					$error("token beat with no token predicted: kind %0d", got.kind);
					fail_count++;
				end else begin
					want = expected_tokens.pop_front();
					bad = check_field("token_kind", 64'(want.tok.kind), 64'(got.kind))
						+ check_field("lead_symbol", 64'(want.tok.lead), 64'(got.lead))
						+ check_field("start_offset", 64'(want.tok.start), 64'(got.start))
						+ check_field("lexeme_length", 64'(want.tok.len), 64'(got.len))
						+ check_field("line_number", 64'(want.tok.line), 64'(got.line))
						+ check_field("number_mantissa", want.tok.mant, got.mant)
						+ check_field("fraction_digits", 64'(want.tok.frac), 64'(got.frac))
						+ check_field("errors_so_far", 64'(want.tok.errors), 64'(got.errors))
						+ check_field("last", 64'(want.last), 64'(m_axis_tlast));
					if (bad != 0) fail_count++;
					tokens_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata);
			if (cap_we) capacity = cap_wdata;
		end
		tokens_pending = expected_tokens.size();
	end

endmodule

@@ sim/tb_c_subset_lexer.sv @@
// Testbench top for c_subset_lexer: builds source texts, drives the byte
// stream and capacity port, and gives the verdict. Depends on clx_pkg,
// c_subset_lexer and clx_token_checker.
module tb_c_subset_lexer;
	timeunit 1ns;
	timeprecision 1ps;
	import clx_pkg::*;

	localparam int CycleLimit = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [175:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         cap_we;
	logic [16:0]  cap_wdata;
	int           fail_count;
	int           tokens_pending;
	int           tokens_checked;

	logic [7:0] text_bytes[$];
	int   bytes_sent;
	int   random_sent;
	int   texts_sent;
	int   cycles;
	bit   steady;
	bit   hold_start;
	int   hold_left;

	c_subset_lexer dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cap_we(cap_we), .cap_wdata(cap_wdata)
	);

	clx_token_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cap_we(cap_we), .cap_wdata(cap_wdata),
		.fail_count(fail_count), .tokens_pending(tokens_pending),
		.tokens_checked(tokens_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bound the run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CycleLimit) begin
				$display("timeout after %0d cycles", cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver: random stalls, long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (steady) m_axis_tready <= 1'b1;
			else m_axis_tready <= ($urandom_range(0, 99) >= 19);
		end
	end

	task push_str(input string s);
		foreach (s[i]) text_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] any_letter();
		string set;
		set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task push_digits(input int n);
		repeat (n) text_bytes.push_back(8'("0") + 8'($urandom_range(0, 9)));
	endtask

	// append one random lexical fragment; long lexemes are rare
	task push_fragment();
		string kw[3];
		string pun;
		int n;
		kw = '{"if", "else", "while"};
		pun = "+-*/(){};";
		case ($urandom_range(0, 60))
			0, 1, 2: push_str(kw[$urandom_range(0, 2)]);
			3, 4, 5, 6: begin
				text_bytes.push_back(any_letter());
				repeat ($urandom_range(0, 7))
					if ($urandom_range(0, 3) == 0) push_digits(1);
					else text_bytes.push_back(any_letter());
			end
			7, 8, 9, 10: begin
				push_digits($urandom_range(1, 6));
				if ($urandom_range(0, 1)) begin
					push_str(".");
					push_digits($urandom_range(0, 4));
				end
			end
			11, 12, 13, 14: begin
				n = $urandom_range(0, 3);
				text_bytes.push_back(n == 0 ? "<" : n == 1 ? ">" : n == 2 ? "=" : "!");
				if ($urandom_range(0, 1)) push_str("=");
			end
			15, 16, 17, 18, 19, 20: text_bytes.push_back(pun[$urandom_range(0, pun.len() - 1)]);
			21, 22, 23, 24, 25, 26: text_bytes.push_back(8'($urandom_range(9, 13)));
			27, 28, 29, 30, 31, 32, 33: push_str(" ");
			34, 35: begin
				push_str("//");
				repeat ($urandom_range(0, 6)) text_bytes.push_back(8'($urandom_range(1, 255)));
				if ($urandom_range(0, 3) != 0) text_bytes.push_back(8'd10);
			end
			36, 37, 38, 39: text_bytes.push_back(8'($urandom_range(1, 255)));
			40: repeat ($urandom_range(63, 66)) text_bytes.push_back(any_letter());
			41: begin
				push_digits(63);
				if ($urandom_range(0, 1)) push_str(".5");
			end
			42: begin
				push_digits(61);
				push_str(".");
				push_digits(2);
			end
			43: begin
				push_str("7.");
				push_digits($urandom_range(60, 64));
			end
			44: push_str("99999999999999999999999 ");
			45, 46: begin
				push_digits($urandom_range(1, 3));
				push_str(".");
				text_bytes.push_back($urandom_range(0, 1) ? "x" : " ");
			end
			default: push_str(" ");
		endcase
	endtask

	task send_byte(input logic [7:0] b);
		bit ready;
		if (!steady && $urandom_range(0, 99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do begin
			@(negedge clk);
			ready = s_axis_tready;
			@(posedge clk);
		end while (!ready);
		bytes_sent++;
		if (b == 8'd0) texts_sent++;
	endtask

	task send_queued();
		while (text_bytes.size() > 0) send_byte(text_bytes.pop_front());
		s_axis_tvalid <= 1'b0;
	endtask

	// random texts, each closed by its end byte
	task send_random(input int count);
		int target;
		target = random_sent + count;
		while (random_sent < target) begin
			push_fragment();
			if ($urandom_range(0, 29) == 0) text_bytes.push_back(8'd0);
			random_sent += text_bytes.size();
			send_queued();
		end
		text_bytes.push_back(8'd0);
		send_queued();
	endtask

	// wait until the last accepted byte is folded into the prediction
	task drain_tokens();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_capacity(input logic [16:0] value);
		drain_tokens();
		cap_we <= 1'b1;
		cap_wdata <= value;
		@(posedge clk);
		cap_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cap_we = 1'b0;
		cap_wdata = '0;
		steady = 1'b0;
		hold_start = 1'b0;
		bytes_sent = 0;
		random_sent = 0;
		texts_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keywords, pairs, lone bang, point cases, punctuation, comment
		push_str("if else while<=!=!x\n1.5 3.;(){}+-*/=//c\n>");
		text_bytes.push_back(8'hFF);
		text_bytes.push_back(8'd0);
		send_queued();

		write_capacity(17'd65536);
		send_random(45);
		// long receiver hold-off while bytes keep coming
		hold_start = 1'b1;
		send_random(30);
		// pause the sender mid-text until all tokens are out
		push_str("a1 <");
		send_queued();
		drain_tokens();
		push_str("= 42");
		text_bytes.push_back(8'd0);
		send_queued();

		write_capacity(17'd4);
		send_random(20);
		write_capacity(17'd131071);
		steady = 1'b1;
		send_random(40);
		steady = 1'b0;
		write_capacity(17'd0);
		send_random(10);
		write_capacity(17'd1);
		send_random(10);
		write_capacity(17'd2);
		send_random(10);
		write_capacity(17'd1024);
		send_random(60);

		drain_tokens();
		repeat (20) @(posedge clk);
		$display("sent %0d bytes in %0d texts, checked %0d tokens over seven capacities",
			bytes_sent, texts_sent, tokens_checked);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
